// ===== rtl/aml_pkg.sv =====
// Package with the opcodes, phase encoding and result type of the AML sleep-state parser.
`default_nettype none

package aml_pkg;

    // AML opcodes and markers recognized by the parser.
    localparam logic [7:0]  OP_NAME        = 8'h08;
    localparam logic [7:0]  CH_ROOT        = 8'h5C;
    localparam logic [7:0]  OP_PACKAGE     = 8'h12;
    localparam logic [7:0]  OP_BYTEPREFIX  = 8'h0A;
    localparam logic [7:0]  PKGLEN_MASK    = 8'hC0;
    localparam int          VALUE_SHIFT    = 10;
    localparam logic [31:0] NAME_RESET     = 32'h5F53355F;

    // Window of recent bytes kept while searching.
    localparam int          WINDOW_BYTES   = 6;
    localparam int          FILL_W         = 3;

    // Result status codes.
    localparam logic [1:0]  ST_FOUND       = 2'd0;
    localparam logic [1:0]  ST_ABSENT      = 2'd1;
    localparam logic [1:0]  ST_ERROR       = 2'd2;

    // Parse phases, one-hot.
    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_PKGOP  = 6'b000010,
        PH_PKGLEN = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_VAL_A  = 6'b010000,
        PH_VAL_B  = 6'b100000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [15:0] value_b;
        logic [15:0] value_a;
        logic [1:0]  status;
    } result_t;

    // Value byte shifted into its sleep-type position, truncated to 16 bits.
    function automatic logic [15:0] shifted_value(input logic [7:0] b);
        logic [31:0] wide;
        wide = {24'd0, b} << VALUE_SHIFT;
        return wide[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/aml_parse_core.sv =====
// Per-stream parse state and the combinational next-state and result logic.
`default_nettype none

module aml_parse_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last,
    input  wire logic [31:0]     target_name,
    output logic                 produce,
    output aml_pkg::result_t     result
);
    import aml_pkg::*;

    logic [8*WINDOW_BYTES-1:0] window_reg, window_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    phase_t                    phase_reg, phase_next;
    logic [2:0]                skip_reg, skip_next;
    logic [15:0]               held_a_reg, held_a_next;
    logic                      reported_reg, reported_next;

    logic [8*WINDOW_BYTES-1:0] win_shift;
    logic [FILL_W-1:0]         fill_inc;
    logic                      name_hit;
    logic                      prefix_ok;
    logic                      hit;
    result_t                   res;

    // Window candidate and name compare for the search phase.
    always_comb
    begin
        win_shift = {window_reg[8*WINDOW_BYTES-9:0], data_byte};
        fill_inc  = (fill_reg < FILL_W'(WINDOW_BYTES)) ? fill_reg + 1'b1 : fill_reg;
        name_hit  = (fill_inc >= FILL_W'(4)) && (win_shift[31:0] == target_name);
        prefix_ok = ((fill_inc >= FILL_W'(5)) && (win_shift[39:32] == OP_NAME)) ||
                    ((fill_inc >= FILL_W'(6)) && (win_shift[47:40] == OP_NAME) &&
                     (win_shift[39:32] == CH_ROOT));
    end

    // Phase update and result decision for one item.
    always_comb
    begin
        window_next  = window_reg;
        fill_next    = fill_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        held_a_next  = held_a_reg;
        hit          = 1'b0;
        res.status   = ST_FOUND;
        res.value_a  = 16'd0;
        res.value_b  = 16'd0;

        if (!reported_reg)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    window_next = win_shift;
                    fill_next   = fill_inc;
                    if (name_hit)
                    begin
                        if (prefix_ok)
                        begin
                            phase_next = PH_PKGOP;
                        end
                        else
                        begin
                            res.status = ST_ERROR;
                            hit        = 1'b1;
                        end
                    end
                end
                PH_PKGOP:
                begin
                    if (data_byte == OP_PACKAGE)
                    begin
                        phase_next = PH_PKGLEN;
                    end
                    else
                    begin
                        res.status = ST_ERROR;
                        hit        = 1'b1;
                    end
                end
                PH_PKGLEN:
                begin
                    // Lead byte plus lead[7:6] follow-on bytes, then the element count.
                    skip_next  = {1'b0, data_byte[7:6]} + 3'd1;
                    phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 3'd1;
                    if (skip_reg <= 3'd1)
                    begin
                        skip_next  = 3'd0;
                        phase_next = PH_VAL_A;
                    end
                end
                PH_VAL_A:
                begin
                    if (skip_reg == 3'd0 && data_byte == OP_BYTEPREFIX)
                    begin
                        skip_next = 3'd1;
                    end
                    else
                    begin
                        held_a_next = shifted_value(data_byte);
                        skip_next   = 3'd0;
                        phase_next  = PH_VAL_B;
                    end
                end
                PH_VAL_B:
                begin
                    if (skip_reg == 3'd0 && data_byte == OP_BYTEPREFIX)
                    begin
                        skip_next = 3'd1;
                    end
                    else
                    begin
                        res.status  = ST_FOUND;
                        res.value_a = held_a_reg;
                        res.value_b = shifted_value(data_byte);
                        hit         = 1'b1;
                    end
                end
                default:
                begin
                    res.status = ST_ERROR;
                    hit        = 1'b1;
                end
            endcase

            // End of stream without a result: absent while still searching after
            // this byte, truncated once a name has been matched.
            if (!hit && last)
            begin
                res.status = (phase_next == PH_SEARCH) ? ST_ABSENT : ST_ERROR;
                hit        = 1'b1;
            end
        end

        reported_next = reported_reg | hit;
        produce       = hit;
        result        = res;
    end

    // State registers; a last byte returns the stream state to its start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            fill_reg     <= '0;
            phase_reg    <= PH_SEARCH;
            skip_reg     <= '0;
            held_a_reg   <= '0;
            reported_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                window_reg   <= '0;
                fill_reg     <= '0;
                phase_reg    <= PH_SEARCH;
                skip_reg     <= '0;
                held_a_reg   <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                window_reg   <= window_next;
                fill_reg     <= fill_next;
                phase_reg    <= phase_next;
                skip_reg     <= skip_next;
                held_a_reg   <= held_a_next;
                reported_reg <= reported_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aml_sleep_state_parser_unit.sv =====
// Top level of the AML sleep-state parser: input register, parse core, result register.
//
// Usage: bytes of an ACPI definition block enter on the s_ channel, one byte per
// item, with s_tlast on the final byte. The block looks for the first occurrence
// of the name in cfg_data's register (reset "_S5_"), which must be preceded by NameOp and
// followed by PackageOp, then reads two sleep-type bytes. Exactly one result
// item per stream leaves on the m_ channel: found with both values, name not
// present, or parse error / truncated stream.
// A byte that yields a result passes the input register and then the result
// register, whose valid bit drives m_tvalid.
// Throughput: one byte per cycle unless a result is held for a stalled receiver; the parse step is a
// single compare and phase update between the input register and the result register.
// When the receiver stalls, the result is held in the output register; the
// input register still takes a byte, and the core keeps consuming bytes that
// give no result. Only a byte that would give a second pending result waits.
// Reset clears the stream state and sets the name register to "_S5_".
// cfg_ready is always high; write the name only while the block is idle.
`default_nettype none

module aml_sleep_state_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write: target name, first byte in bits 31:24.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Input bytes. s_tdata: data_byte[7:0].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // Results. m_tdata: status[1:0], control_value_a[17:2], control_value_b[33:18], zero pad.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);
    import aml_pkg::*;

    logic [31:0] target_reg;
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        produce;
    result_t     result;
    logic        out_free;
    logic        step;

    // Name register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= NAME_RESET;
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    // Handshake: a held byte advances unless it yields a result that cannot be stored.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!produce || out_free);
    assign s_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse core.
    aml_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_data_reg),
        .last        (in_last_reg),
        .target_name (target_reg),
        .produce     (produce),
        .result      (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.value_b, out_reg.value_a, out_reg.status};

endmodule

`default_nettype wire

// ===== verif/aml_sleep_state_checker.sv =====
// Result checker for the AML sleep-state parser: tracks the parse of accepted bytes and compares results.
`default_nettype none

module aml_sleep_state_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,    // data_byte[7:0]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,    // status[1:0], value_a[17:2], value_b[33:18], pad
    output int               errors,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import aml_pkg::*;

    // Shadow copy of the name register and the per-stream parse state.
    logic [31:0] target_name;
    logic [47:0] recent_bytes;
    logic [2:0]  recent_fill;
    phase_t      phase;
    logic [2:0]  bytes_to_skip;
    logic [15:0] first_value;
    logic        stream_done;

    // Results still owed by the block, oldest first.
    result_t     expected_q[$];

    // Sleep-type byte moved to its field position, cut to 16 bits.
    function automatic logic [15:0] sleep_type_field(input logic [7:0] b);
        logic [15:0] w;
        w = {8'h00, b};
        return w << VALUE_SHIFT;
    endfunction

    function automatic void clear_stream();
        recent_bytes  = '0;
        recent_fill   = '0;
        phase         = PH_SEARCH;
        bytes_to_skip = '0;
        first_value   = '0;
        stream_done   = 1'b0;
    endfunction

    // Advance the parse by one byte and queue the result it causes, if any.
    function automatic void parse_byte(input logic [7:0] b, input logic lst);
        result_t res;
        logic    hit;
        logic    prefix_ok;
        res = '0;
        hit = 1'b0;
        if (!stream_done)
        begin
            case (phase)
                PH_SEARCH:
                begin
                    recent_bytes = {recent_bytes[39:0], b};
                    if (recent_fill < 3'd6)
                        recent_fill = recent_fill + 3'd1;
                    if (recent_fill >= 3'd4 && recent_bytes[31:0] == target_name)
                    begin
                        // NameOp right before the name, or NameOp then a root backslash.
                        prefix_ok = (recent_fill >= 3'd5 && recent_bytes[39:32] == OP_NAME) ||
                                    (recent_fill >= 3'd6 && recent_bytes[47:40] == OP_NAME &&
                                     recent_bytes[39:32] == CH_ROOT);
                        if (prefix_ok)
                            phase = PH_PKGOP;
                        else
                        begin
                            res.status = ST_ERROR;
                            hit = 1'b1;
                        end
                    end
                end
                PH_PKGOP:
                begin
                    if (b == OP_PACKAGE)
                        phase = PH_PKGLEN;
                    else
                    begin
                        res.status = ST_ERROR;
                        hit = 1'b1;
                    end
                end
                PH_PKGLEN:
                begin
                    // Extra length bytes plus the element count.
                    bytes_to_skip = 3'((b & PKGLEN_MASK) >> 6) + 3'd1;
                    phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (bytes_to_skip != 3'd0)
                        bytes_to_skip = bytes_to_skip - 3'd1;
                    if (bytes_to_skip == 3'd0)
                        phase = PH_VAL_A;
                end
                PH_VAL_A:
                begin
                    if (bytes_to_skip == 3'd0 && b == OP_BYTEPREFIX)
                        bytes_to_skip = 3'd1;
                    else
                    begin
                        first_value = sleep_type_field(b);
                        bytes_to_skip = 3'd0;
                        phase = PH_VAL_B;
                    end
                end
                PH_VAL_B:
                begin
                    if (bytes_to_skip == 3'd0 && b == OP_BYTEPREFIX)
                        bytes_to_skip = 3'd1;
                    else
                    begin
                        res.status  = ST_FOUND;
                        res.value_a = first_value;
                        res.value_b = sleep_type_field(b);
                        hit = 1'b1;
                    end
                end
                default:
                begin
                    res.status = ST_ERROR;
                    hit = 1'b1;
                end
            endcase
            // End of stream without a result: absent while searching, truncated otherwise.
            if (!hit && lst)
            begin
                res.status = (phase == PH_SEARCH) ? ST_ABSENT : ST_ERROR;
                hit = 1'b1;
            end
            if (hit)
                stream_done = 1'b1;
        end
        if (hit)
            expected_q.push_back(res);
        if (lst)
            clear_stream();
    endfunction

    // Compare one result item with the oldest expectation.
    function automatic void compare_result(input logic [39:0] word);
        result_t got;
        result_t want;
        got = word[33:0];
        if (expected_q.size() == 0)
        begin
            $error("unexpected result item: status %0d, control_value_a %0h, control_value_b %0h",
                   got.status, got.value_a, got.value_b);
            errors++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.value_a !== want.value_a)
            begin
                $error("control_value_a: expected %0h, actual %0h", want.value_a, got.value_a);
                errors++;
            end
            if (got.value_b !== want.value_b)
            begin
                $error("control_value_b: expected %0h, actual %0h", want.value_b, got.value_b);
                errors++;
            end
            if (word[39:34] !== 6'd0)
            begin
                $error("m_tdata pad: expected 0, actual %0h", word[39:34]);
                errors++;
            end
        end
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            target_name = NAME_RESET;
            clear_stream();
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_name = cfg_data;
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
        end
        outstanding = expected_q.size();
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench top for the AML sleep-state parser: clock, reset, byte streams, name writes and verdict.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aml_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int DIRECTED_MAX  = 25;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 6;

    typedef enum int {
        SK_GOOD,
        SK_CUT,
        SK_BAD_PREFIX,
        SK_BAD_PKG,
        SK_ABSENT,
        SK_NOISE
    } stream_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;          // data_byte[7:0]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;               // status[1:0], value_a[17:2], value_b[33:18], pad

    int          errors;
    int          outstanding;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    logic [31:0] name_now = NAME_RESET;
    logic [31:0] phase_names [NUM_PHASES];
    logic [7:0]  frame_q[$];

    aml_sleep_state_parser_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    aml_sleep_state_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Result receiver stalls at random with the current stall rate.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if no item moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Biased byte: AML opcodes and bytes of the current name show up often.
    function automatic logic [7:0] filler_byte();
        int k;
        k = $urandom_range(3);
        case ($urandom_range(9))
            0: return OP_NAME;
            1: return CH_ROOT;
            2: return OP_PACKAGE;
            3: return OP_BYTEPREFIX;
            4: return name_now[8*k +: 8];
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_name();
        for (int k = 3; k >= 0; k--)
            frame_q.push_back(name_now[8*k +: 8]);
    endfunction

    // Build one definition-block stream of the given kind into frame_q.
    function automatic void build_stream(input stream_kind_t kind);
        logic [7:0] b;
        logic [7:0] lead;
        int         cut;
        frame_q.delete();
        if (kind == SK_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                frame_q.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind == SK_ABSENT)
        begin
            repeat ($urandom_range(1, 10))
                frame_q.push_back(filler_byte());
            return;
        end
        repeat ($urandom_range(0, 6))
            frame_q.push_back(filler_byte());
        if (kind == SK_BAD_PREFIX)
        begin
            // Either no byte at all before the name, or a wrong one.
            if ($urandom_range(1) == 0)
                frame_q.delete();
            else
            begin
                do b = 8'($urandom_range(255)); while (b == OP_NAME);
                frame_q.push_back(b);
            end
        end
        else
        begin
            frame_q.push_back(OP_NAME);
            if ($urandom_range(1) == 0)
                frame_q.push_back(CH_ROOT);
        end
        push_name();
        if (kind == SK_BAD_PKG)
        begin
            do b = 8'($urandom_range(255)); while (b == OP_PACKAGE);
            frame_q.push_back(b);
        end
        else
            frame_q.push_back(OP_PACKAGE);
        // Package length lead byte, its extra bytes, then the element count.
        lead = 8'($urandom_range(255));
        frame_q.push_back(lead);
        repeat (lead[7:6])
            frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(8'($urandom_range(255)));
        // Two sleep-type values, each with an optional byte prefix.
        repeat (2)
        begin
            if ($urandom_range(2) == 0)
                frame_q.push_back(OP_BYTEPREFIX);
            frame_q.push_back(($urandom_range(5) == 0) ? OP_BYTEPREFIX : 8'($urandom_range(255)));
        end
        repeat ($urandom_range(0, 4))
            frame_q.push_back(filler_byte());
        if (kind == SK_CUT)
        begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endfunction

    function automatic stream_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return SK_GOOD;
        if (r < 65)
            return SK_CUT;
        if (r < 72)
            return SK_BAD_PREFIX;
        if (r < 79)
            return SK_BAD_PKG;
        if (r < 89)
            return SK_ABSENT;
        return SK_NOISE;
    endfunction

    // Offer one byte, with random idle cycles first; returns at a falling edge.
    task automatic send_item(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_item(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Stop sending until every owed result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write the name register while the block is idle.
    task automatic write_name(input logic [31:0] value);
        drain();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        name_now = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        bit first_stream;
        phase_names[0] = NAME_RESET;
        phase_names[1] = 32'h0000_0000;
        phase_names[2] = 32'hFFFF_FFFF;
        phase_names[3] = 32'($urandom());
        phase_names[4] = 32'h5F53_335F;
        phase_names[5] = NAME_RESET;

        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Name at the very start of the stream: no bytes before it, so a parse error.
        frame_q.delete();
        push_name();
        frame_q.push_back(8'h00);
        send_frame();

        // Root-prefixed name, longer package length, both values prefixed,
        // first value equal to the prefix byte, last byte carries the result.
        frame_q.delete();
        frame_q.push_back(OP_NAME);
        frame_q.push_back(CH_ROOT);
        push_name();
        frame_q.push_back(OP_PACKAGE);
        frame_q.push_back(8'h40);
        frame_q.push_back(8'h77);
        frame_q.push_back(8'h02);
        frame_q.push_back(OP_BYTEPREFIX);
        frame_q.push_back(OP_BYTEPREFIX);
        frame_q.push_back(OP_BYTEPREFIX);
        frame_q.push_back(8'hFF);
        send_frame();

        // Single-byte stream without the name.
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();

        // Stream cut right after the name.
        frame_q.delete();
        frame_q.push_back(OP_NAME);
        push_name();
        send_frame();

        // Random phases: a name write before each but the first, and one of four idling patterns.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                write_name(phase_names[p]);
            @(posedge clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            @(negedge clk);
            first_stream = 1'b1;
            while (items_sent < DIRECTED_MAX + (p + 1) * RANDOM_ITEMS / NUM_PHASES)
            begin
                build_stream(pick_kind());
                send_frame();
                if (first_stream || $urandom_range(15) == 0)
                    drain();
                first_stream = 1'b0;
            end
        end

        drain();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/aml_pkg.sv
rtl/aml_parse_core.sv
rtl/aml_sleep_state_parser_unit.sv
verif/aml_sleep_state_checker.sv
verif/tb_top.sv
